>>> hw/rtl/pbsa_pkg.sv
// shared types and constants of the packet buffer slot allocator
package pbsa_pkg;

  localparam int SLOT_W  = 11;
  localparam int COUNT_W = 12;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 64;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int POINTER_SPAN = 2048;

  localparam logic OP_ASSIGN  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic FLAG_FREE     = 1'b0;
  localparam logic FLAG_INFLIGHT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DMA_BASE    = 2'd3;

  localparam logic [COUNT_W-1:0] RST_SLOT_COUNT  = 12'd2048;
  localparam logic [SLOT_W-1:0]  RST_SLOT_OFFSET = 11'd0;
  localparam logic [SIZE_W-1:0]  RST_BUFFER_SIZE = 16'd2048;
  localparam logic [ADDR_W-1:0]  RST_DMA_BASE    = 64'd0;

  typedef struct packed {
    logic load;
    logic wr_clear;
    logic wr_release;
    logic setup;
    logic advance;
    logic hit;
    logic mul;
    logic add;
  } pbsa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rem_busy;
    logic op_release;
    logic count_zero;
    logic slot_free;
    logic last;
  } pbsa_status_t;

endpackage

>>> hw/rtl/packet_buffer_slot_allocator.sv
// Packet buffer slot allocator, top level. After reset the block runs a
// clearing pass over the flag store, one slot per cycle, with busy high;
// configuration writes are taken meanwhile. A command is taken when start is
// high and busy is low, and its result is shown for exactly one cycle with
// done high; the receiver cannot stall it, so it must take the transfer in
// that cycle. Busy falls at the edge that ends the done cycle, so the next
// command can be taken in the cycle after the result. Every command first
// reduces a slot index modulo the store depth: the release slot for a
// release, the slot offset for an assign. A release then clears the flag of
// the reduced slot. An assign examines k slots, where k is at most the
// effective slot count (none with a zero slot count); each examined slot
// costs one read of the single-bit flag memory and a test of the read flag.
// When a slot is free it is marked in flight and its DMA address is formed by
// a multiply and an add; otherwise no slot is granted.
module packet_buffer_slot_allocator import pbsa_pkg::*; #(
  parameter int SLOT_STORE_DEPTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  input  logic                 opcode,
  input  logic [SLOT_W-1:0]    release_slot,
  output logic                 granted,
  output logic [SLOT_W-1:0]    slot,
  output logic [ADDR_W-1:0]    dma_address,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pbsa_cmd_t    cmd;
  pbsa_status_t st;

  pbsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pbsa_dp #(
    .SLOT_STORE_DEPTH (SLOT_STORE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .opcode       (opcode),
    .release_slot (release_slot),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .granted      (granted),
    .slot         (slot),
    .dma_address  (dma_address)
  );

endmodule

>>> hw/rtl/pbsa_ram.sv
// generic single write, single read ram with registered read data
module pbsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pbsa_rem.sv
// remainder of a narrow value by the store depth, by reciprocal multiplication
module pbsa_rem #(
  parameter int DEPTH = 2048,
  parameter int X_W   = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [X_W-1:0]           x,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] rem
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SH    = X_W + IDX_W;
  localparam int M_W   = X_W + 2;
  localparam int P_W   = X_W + M_W;
  localparam int QD_W  = X_W + IDX_W + 1;
  // ceil(2^SH / DEPTH) gives an exact quotient for every X_W-bit dividend
  localparam longint RECIP_V =
    ((longint'(1) << SH) + longint'(DEPTH) - longint'(1)) / longint'(DEPTH);
  localparam logic [M_W-1:0]  RECIP   = M_W'(RECIP_V);
  localparam logic [IDX_W:0]  DEPTH_V = (IDX_W + 1)'(DEPTH);

  logic             xs_vld;
  logic             prod_vld;
  logic [X_W-1:0]   xs;
  logic [P_W-1:0]   prod;
  logic [X_W-1:0]   quo;
  logic [QD_W-1:0]  qd;
  logic [QD_W-1:0]  diff;
  logic [IDX_W-1:0] r;

  always_comb begin
    quo  = X_W'(prod >> SH);
    qd   = QD_W'(quo) * QD_W'(DEPTH_V);
    diff = QD_W'(xs) - qd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xs_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      xs_vld   <= start;
      prod_vld <= xs_vld;
    end
  end

  // quotient estimate first, then subtract quotient times depth
  always_ff @(posedge clk) begin
    if (start) begin
      xs <= x;
    end
    if (xs_vld) begin
      prod <= P_W'(xs) * P_W'(RECIP);
    end
    if (prod_vld) begin
      r <= diff[IDX_W-1:0];
    end
  end

  assign busy = xs_vld | prod_vld;
  assign rem  = r;

endmodule

>>> hw/rtl/pbsa_dp.sv
// datapath: configuration, flag store, search registers and address unit
module pbsa_dp import pbsa_pkg::*; #(
  parameter int SLOT_STORE_DEPTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbsa_cmd_t            cmd,
  output pbsa_status_t         st,
  input  logic                 opcode,
  input  logic [SLOT_W-1:0]    release_slot,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 granted,
  output logic [SLOT_W-1:0]    slot,
  output logic [ADDR_W-1:0]    dma_address
);

  localparam int IDX_W = $clog2(SLOT_STORE_DEPTH);
  localparam int LIM   = (SLOT_STORE_DEPTH < POINTER_SPAN) ? SLOT_STORE_DEPTH : POINTER_SPAN;
  localparam logic [COUNT_W-1:0] EFF_LIM = COUNT_W'(LIM);
  localparam int SUM_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(SLOT_STORE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_STORE_DEPTH - 1);

  // configuration registers
  logic [COUNT_W-1:0] slot_count;
  logic [SLOT_W-1:0]  slot_offset;
  logic [SIZE_W-1:0]  buffer_size;
  logic [ADDR_W-1:0]  dma_base;

  // search state
  logic [SLOT_W-1:0]  search_pointer;
  logic               op;
  logic [COUNT_W-1:0] count_n;
  logic [COUNT_W-1:0] remaining;
  logic [SLOT_W-1:0]  pos;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   offmod;
  logic [IDX_W-1:0]   clr_cnt;
  logic [2*SIZE_W-1:0] prod;

  logic [COUNT_W-1:0] n_eff;
  logic [SLOT_W-1:0]  start_pos;
  logic [COUNT_W-1:0] pos_inc;
  logic               pos_wrap;
  logic [SLOT_W-1:0]  pos_next;
  logic [IDX_W-1:0]   idx_inc;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_red;

  logic               rem_busy;
  logic [IDX_W-1:0]   rem;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic               ram_wdata;
  logic               ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= RST_SLOT_COUNT;
      slot_offset <= RST_SLOT_OFFSET;
      buffer_size <= RST_BUFFER_SIZE;
      dma_base    <= RST_DMA_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOT_COUNT:  slot_count  <= cfg_data[COUNT_W-1:0];
        REG_SLOT_OFFSET: slot_offset <= cfg_data[SLOT_W-1:0];
        REG_BUFFER_SIZE: buffer_size <= cfg_data[SIZE_W-1:0];
        REG_DMA_BASE:    dma_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff     = (slot_count < EFF_LIM) ? slot_count : EFF_LIM;
    start_pos = ({1'b0, search_pointer} >= n_eff) ? '0 : search_pointer;
    pos_inc   = {1'b0, pos} + 1'b1;
    pos_wrap  = (pos_inc >= count_n);
    pos_next  = pos_wrap ? '0 : pos_inc[SLOT_W-1:0];
    idx_inc   = (idx == IDX_LAST) ? '0 : idx + 1'b1;
    sum       = SUM_W'(rem) + SUM_W'(pos);
    sum_red   = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
  end

  // offset or release slot reduced modulo the store depth
  pbsa_rem #(
    .DEPTH (SLOT_STORE_DEPTH),
    .X_W   (COUNT_W)
  ) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load),
    .x     ((opcode == OP_RELEASE) ? {1'b0, release_slot} : {1'b0, slot_offset}),
    .busy  (rem_busy),
    .rem   (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pointer <= '0;
      clr_cnt        <= '0;
    end else begin
      if (cmd.wr_clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.hit) begin
        search_pointer <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op          <= opcode;
      count_n     <= n_eff;
      remaining   <= n_eff;
      pos         <= start_pos;
      granted     <= 1'b0;
      slot        <= '0;
      dma_address <= '0;
    end
    if (cmd.setup) begin
      offmod <= rem;
      idx    <= sum_red[IDX_W-1:0];
    end
    if (cmd.advance) begin
      remaining <= remaining - 1'b1;
      pos       <= pos_next;
      idx       <= pos_wrap ? offmod : idx_inc;
    end
    if (cmd.hit) begin
      granted <= 1'b1;
      slot    <= SLOT_W'(idx);
    end
    if (cmd.mul) begin
      prod <= buffer_size * SIZE_W'(idx);
    end
    if (cmd.add) begin
      dma_address <= dma_base + {{(ADDR_W - 2*SIZE_W){1'b0}}, prod};
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = FLAG_FREE;
    if (cmd.wr_clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
    end else if (cmd.wr_release) begin
      ram_we    = 1'b1;
      ram_waddr = rem;
    end else if (cmd.hit) begin
      ram_we    = 1'b1;
      ram_wdata = FLAG_INFLIGHT;
    end
  end

  pbsa_ram #(
    .WIDTH (1),
    .DEPTH (SLOT_STORE_DEPTH)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    st.clr_last   = (clr_cnt == IDX_LAST);
    st.rem_busy   = rem_busy;
    st.op_release = (op == OP_RELEASE);
    st.count_zero = (remaining == '0);
    st.slot_free  = (ram_rdata == FLAG_FREE);
    st.last       = (remaining == COUNT_W'(1));
  end

endmodule

>>> hw/rtl/pbsa_ctrl.sv
// controller state machine of the slot allocator
module pbsa_ctrl import pbsa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  pbsa_status_t st,
  output pbsa_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SETUP,
    ST_READ,
    ST_CHECK,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (st.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!st.rem_busy) begin
          if (st.op_release) begin
            cmd.wr_release = 1'b1;
            state_next     = ST_DONE;
          end else begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = st.count_zero ? ST_DONE : ST_READ;
      end
      // flag read is registered, so the data is looked at in ST_CHECK
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (st.slot_free) begin
          cmd.hit    = 1'b1;
          state_next = ST_MUL;
        end else if (st.last) begin
          state_next = ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
      done  <= (state_next == ST_DONE);
    end
  end

endmodule
